>>> design/ged_pkg.sv
// ----------------------------------------------------------------------------
// ged_pkg
// Shared types and constants for the gossip event duplicate filter and
// reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ged_pkg;

  localparam int NEIGHBORS_DEF  = 8;
  localparam int HOLD_DEPTH_DEF = 4;
  localparam int ID_BITS        = 8;
  localparam int TAG_BITS       = 16;

  localparam logic [7:0]  ID_MASK  = 8'((64'd1 << ID_BITS) - 64'd1);
  localparam logic [15:0] TAG_MASK = 16'((64'd1 << TAG_BITS) - 64'd1);

  localparam logic [7:0] SELF_ID_RESET  = 8'd1;
  localparam logic [7:0] MAX_HOPS_RESET = 8'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HOPS = 2'd1;

  localparam logic [1:0] KIND_ACCEPT   = 2'd0;
  localparam logic [1:0] KIND_DUP      = 2'd1;
  localparam logic [1:0] KIND_GAP      = 2'd2;
  localparam logic [1:0] KIND_RELEASED = 2'd3;

  typedef struct packed {
    logic [7:0]  src_id;
    logic [31:0] src_seq;
    logic [7:0]  hops;
    logic [7:0]  sender_id;
    logic [15:0] event_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_origin;
    logic [31:0] out_seq;
    logic [15:0] out_tag;
    logic        forward_now;
    logic [7:0]  forward_hops;
    logic [7:0]  exclude_neighbor;
    logic        hops_expired;
    logic [31:0] request_from;
    logic [31:0] request_to;
    logic        was_buffered;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [7:0]  origin;
    logic [31:0] seq;
    logic [15:0] tag;
  } held_t;

endpackage

`default_nettype wire

>>> design/ged_table.sv
// ----------------------------------------------------------------------------
// ged_table
// Per-origin table: ids in registers for the search, highest sequences in a
// synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ged_table #(
  parameter int NEIGHBORS = 8,
  localparam int TD = NEIGHBORS + 1,
  localparam int IW = $clog2(TD)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          self_we,
  input  wire logic [7:0]    self_id,
  input  wire logic [7:0]    key,
  output logic               hit,
  output logic [IW-1:0]      idx,
  input  wire logic [IW-1:0] rd_addr,
  output logic [31:0]        rd_data,
  input  wire logic          set_en,
  input  wire logic          set_hit,
  input  wire logic [IW-1:0] set_idx,
  input  wire logic [7:0]    set_id,
  input  wire logic [31:0]   set_seq
);
  import ged_pkg::*;

  localparam int CW = $clog2(TD + 1);

  logic [7:0]    ids [TD];
  logic [31:0]   seqs [TD];
  logic [CW-1:0] count;
  logic          seq0_written;
  logic [31:0]   rd_raw;
  logic          rd_zero;

  // Lowest matching slot wins, so scan from the top down.
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = TD - 1; i >= 0; i--) begin
      if ((CW'(i) < count) && (ids[i] == key)) begin
        hit = 1'b1;
        idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ids[0]       <= SELF_ID_RESET & ID_MASK;
      count        <= CW'(1);
      seq0_written <= 1'b0;
    end else begin
      if (self_we) begin
        ids[0] <= self_id & ID_MASK;
      end
      if (set_en) begin
        if (set_hit) begin
          if (set_idx == '0) begin
            seq0_written <= 1'b1;
          end
        end else if (count < CW'(TD)) begin
          ids[count[IW-1:0]] <= set_id;
          count              <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_en) begin
      if (set_hit) begin
        seqs[set_idx] <= set_seq;
      end else if (count < CW'(TD)) begin
        seqs[count[IW-1:0]] <= set_seq;
      end
    end
    rd_raw  <= seqs[rd_addr];
    rd_zero <= (rd_addr == '0) && !seq0_written;
  end

  // Slot zero's sequence is zero until it is first written.
  assign rd_data = rd_zero ? 32'd0 : rd_raw;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(1)) && (count <= CW'(TD)))
    else $error("table fill count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !(set_en && !set_hit) |=> (count == $past(count)) || $past(rst))
    else $error("table count changed without an append");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit |-> (CW'(idx) < count))
    else $error("table hit beyond filled slots");

endmodule

`default_nettype wire

>>> design/ged_hold.sv
// ----------------------------------------------------------------------------
// ged_hold
// Reorder buffer storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ged_hold #(
  parameter int HOLD_DEPTH = 4,
  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire ged_pkg::held_t  wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output ged_pkg::held_t       rd_data
);
  import ged_pkg::*;

  held_t mem [HOLD_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/gossip_event_dedup_reorder_core.sv
// ----------------------------------------------------------------------------
// gossip_event_dedup_reorder_core
// Duplicate filter and gap reorder buffer for received gossip events.
// ----------------------------------------------------------------------------
// One event is handled at a time; the next is taken once the block is back
// in idle. A duplicate or a gap is reported from the lookup state. An
// in-order event then scans the reorder buffer, reading the buffer entry
// and its table sequence for each entry examined and, for each released
// entry, reading and writing every later entry to move it down, because
// every access goes through the single read port of the table memory and
// of the buffer memory. An item occupies the block longest when all
// buffered entries are released. Results pass through a one-deep pending
// register and an output register, so the final result of an item carries
// last_result.
`default_nettype none

module gossip_event_dedup_reorder_core #(
  parameter int NEIGHBORS  = ged_pkg::NEIGHBORS_DEF,
  parameter int HOLD_DEPTH = ged_pkg::HOLD_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ged_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ged_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ged_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import ged_pkg::*;

  localparam int TD = NEIGHBORS + 1;
  localparam int IW = $clog2(TD);
  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HW = $clog2(HOLD_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_LOOK_RD  = 10'b0000000010,
    S_LOOK     = 10'b0000000100,
    S_SCAN_RD  = 10'b0000001000,
    S_SCAN_KEY = 10'b0000010000,
    S_SCAN_SRD = 10'b0000100000,
    S_SCAN_CMP = 10'b0001000000,
    S_SHIFT_RD = 10'b0010000000,
    S_SHIFT_WR = 10'b0100000000,
    S_FLUSH    = 10'b1000000000
  } state_t;

  state_t        state, state_next;
  in_t           item;
  held_t         h;
  logic [7:0]    max_hops;
  logic [HW-1:0] held_count;
  logic [HW-1:0] i, j;
  logic [IW-1:0] idx_r;
  logic          hit_r;
  logic          pend_valid;
  out_t          pend;
  out_t          pend_last;

  logic          self_we;
  logic [7:0]    tbl_key;
  logic          tbl_hit;
  logic [IW-1:0] tbl_idx;
  logic [31:0]   tbl_rdata;
  logic          set_en;
  logic [7:0]    set_id;
  logic [31:0]   set_seq;

  logic          hold_we;
  logic [AW-1:0] hold_waddr;
  held_t         hold_wdata;
  logic [AW-1:0] hold_raddr;
  held_t         hold_rdata;

  logic          out_free, can_push, push;
  out_t          res;
  logic [31:0]   known, known_p1;
  logic          accept_in;
  in_t           in_m;

  assign cfg_ready = 1'b1;
  assign self_we   = cfg_valid && (cfg_index == REG_SELF_ID);
  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;

  always_comb begin
    in_m           = in_data;
    in_m.src_id    = in_data.src_id & ID_MASK;
    in_m.sender_id = in_data.sender_id & ID_MASK;
    in_m.event_tag = in_data.event_tag & TAG_MASK;
  end

  // The final result of an item leaves with its end marker set.
  always_comb begin
    pend_last             = pend;
    pend_last.last_result = 1'b1;
  end

  assign tbl_key  = (state == S_IDLE) ? in_m.src_id : hold_rdata.origin;
  assign known    = hit_r ? tbl_rdata : 32'd0;
  assign known_p1 = known + 32'd1;
  assign out_free = !out_valid || !out_stall;
  assign can_push = !pend_valid || out_free;

  assign hold_raddr = ((state == S_SHIFT_RD) || (state == S_SHIFT_WR))
                      ? AW'(j + HW'(1)) : AW'(i);

  ged_table #(.NEIGHBORS(NEIGHBORS)) u_table (
    .clk     (clk),
    .rst     (rst),
    .self_we (self_we),
    .self_id (cfg_data),
    .key     (tbl_key),
    .hit     (tbl_hit),
    .idx     (tbl_idx),
    .rd_addr (idx_r),
    .rd_data (tbl_rdata),
    .set_en  (set_en),
    .set_hit (hit_r),
    .set_idx (idx_r),
    .set_id  (set_id),
    .set_seq (set_seq)
  );

  ged_hold #(.HOLD_DEPTH(HOLD_DEPTH)) u_hold (
    .clk     (clk),
    .wr_en   (hold_we),
    .wr_addr (hold_waddr),
    .wr_data (hold_wdata),
    .rd_addr (hold_raddr),
    .rd_data (hold_rdata)
  );

  // Next state, result building and memory write controls.
  always_comb begin
    state_next = state;
    push       = 1'b0;
    res        = '0;
    set_en     = 1'b0;
    set_id     = item.src_id;
    set_seq    = item.src_seq;
    hold_we    = 1'b0;
    hold_waddr = AW'(held_count);
    hold_wdata = '{origin: item.src_id, seq: item.src_seq, tag: item.event_tag};
    case (state)
      S_IDLE: begin
        if (accept_in) begin
          state_next = S_LOOK_RD;
        end
      end
      S_LOOK_RD: begin
        state_next = S_LOOK;
      end
      S_LOOK: begin
        res.out_origin = item.src_id;
        res.out_seq    = item.src_seq;
        res.out_tag    = item.event_tag;
        if (can_push) begin
          push = 1'b1;
          if (item.src_seq <= known) begin
            res.result_kind = KIND_DUP;
            state_next      = S_FLUSH;
          end else if (item.src_seq > known_p1) begin
            res.result_kind  = KIND_GAP;
            res.request_from = known_p1;
            res.request_to   = item.src_seq - 32'd1;
            if (held_count < HW'(HOLD_DEPTH)) begin
              hold_we          = 1'b1;
              res.was_buffered = 1'b1;
            end
            state_next = S_FLUSH;
          end else begin
            res.result_kind      = KIND_ACCEPT;
            res.exclude_neighbor = item.sender_id;
            if (item.hops < max_hops) begin
              res.forward_now  = 1'b1;
              res.forward_hops = item.hops + 8'd1;
            end else begin
              res.hops_expired = 1'b1;
            end
            set_en     = 1'b1;
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_next = (i >= held_count) ? S_FLUSH : S_SCAN_KEY;
      end
      S_SCAN_KEY: begin
        state_next = S_SCAN_SRD;
      end
      S_SCAN_SRD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        res.result_kind = KIND_RELEASED;
        res.out_origin  = h.origin;
        res.out_seq     = h.seq;
        res.out_tag     = h.tag;
        set_id          = h.origin;
        set_seq         = h.seq;
        if (h.seq != known_p1) begin
          state_next = S_SCAN_RD;
        end else if (can_push) begin
          push       = 1'b1;
          set_en     = 1'b1;
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        state_next = ((j + HW'(1)) < held_count) ? S_SHIFT_WR : S_SCAN_RD;
      end
      S_SHIFT_WR: begin
        hold_we    = 1'b1;
        hold_waddr = AW'(j);
        hold_wdata = hold_rdata;
        state_next = S_SHIFT_RD;
      end
      S_FLUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      max_hops   <= MAX_HOPS_RESET;
      held_count <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && (cfg_index == REG_MAX_HOPS)) begin
        max_hops <= cfg_data;
      end
      if (push) begin
        pend_valid <= 1'b1;
        out_valid  <= pend_valid || (out_valid && out_stall);
      end else if ((state == S_FLUSH) && out_free) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == S_LOOK) && hold_we) begin
        held_count <= held_count + HW'(1);
      end else if ((state == S_SHIFT_RD) && !((j + HW'(1)) < held_count)) begin
        held_count <= held_count - HW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      item <= in_m;
    end
    if ((state == S_IDLE) || (state == S_SCAN_KEY)) begin
      idx_r <= tbl_idx;
      hit_r <= tbl_hit;
    end
    if (state == S_SCAN_KEY) begin
      h <= hold_rdata;
    end
    if (state == S_LOOK) begin
      i <= '0;
    end else if ((state == S_SCAN_CMP) && (h.seq != known_p1)) begin
      i <= i + HW'(1);
    end
    if (state == S_SCAN_CMP) begin
      j <= i;
    end else if (state == S_SHIFT_WR) begin
      j <= j + HW'(1);
    end
    if (push) begin
      pend <= res;
      if (pend_valid) begin
        out_data <= pend;
      end
    end else if ((state == S_FLUSH) && out_free) begin
      out_data <= pend_last;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= HW'(HOLD_DEPTH))
    else $error("reorder buffer count beyond its depth");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending result left over in idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept_in |=> (state == S_LOOK_RD))
    else $error("accepted transaction did not start a lookup");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push)
    else $error("result pushed without room");

endmodule

`default_nettype wire
